FILE: design/addressable_led_pulse_decoder_top_defines.svh
// Assertion macros for the addressable LED pulse decoder.
// Used by the top level only; no other dependencies.
`ifndef ADDRESSABLE_LED_PULSE_DECODER_TOP_DEFINES_SVH
`define ADDRESSABLE_LED_PULSE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset
`define ALED_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define ALED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/aled_pkg.sv
// Shared types and constants for the addressable LED pulse decoder.
// No dependencies; used by every module of the block except aled_fifo.
`timescale 1ns / 1ps

package aled_pkg;

   // LED store size and field widths
   localparam int MAX_LEDS = 1024;
   localparam int CNT_W    = 11;
   localparam int IDX_W    = 10;
   localparam int T_W      = 32;

   // Pulse timing thresholds in picoseconds
   localparam logic [T_W-1:0] T_FRAME_RESET  = 32'd50_000_000;
   localparam logic [T_W-1:0] T_LOW_MIN      = 32'd400_000;
   localparam logic [T_W-1:0] T_LOW_MAX      = 32'd951_000;
   localparam logic [T_W-1:0] T_LOW_ONE_MAX  = 32'd751_000;
   localparam logic [T_W-1:0] T_LOW_ZERO_MIN = 32'd649_000;
   localparam logic [T_W-1:0] T_HIGH_MIN     = 32'd199_000;
   localparam logic [T_W-1:0] T_HIGH_MAX     = 32'd851_000;
   localparam logic [T_W-1:0] T_HIGH_LONG    = 32'd500_000;

   // Byte slots within one colour, in order of arrival
   localparam logic [1:0] BYTE_GREEN = 2'd0;
   localparam logic [1:0] BYTE_RED   = 2'd1;
   localparam logic [1:0] BYTE_BLUE  = 2'd2;

   // Classified edge, as queued between front and back
   typedef struct packed {
      logic rising;
      logic frame_reset;
      logic low_ok;
      logic low_one;
      logic low_zero;
      logic high_ok;
      logic high_long;
   } edge_class_type;

endpackage

FILE: design/aled_if.sv
// Channel interfaces of the addressable LED pulse decoder: edge words,
// result words and the configuration write. Depends on aled_pkg.
`timescale 1ns / 1ps

interface aled_req_if;
   logic                        valid;
   logic                        ready;
   logic                        edge_rising;
   logic [aled_pkg::T_W-1:0]    interval_ps;

   modport source (output valid, output edge_rising, output interval_ps, input ready);
   modport sink   (input valid, input edge_rising, input interval_ps, output ready);
endinterface

interface aled_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        out_drive;
   logic                        out_level;
   logic                        led_write;
   logic [aled_pkg::IDX_W-1:0]  led_index;
   logic [7:0]                  red;
   logic [7:0]                  green;
   logic [7:0]                  blue;

   modport source (output valid, output out_drive, output out_level, output led_write,
                   output led_index, output red, output green, output blue, input ready);
   modport sink   (input valid, input out_drive, input out_level, input led_write,
                   input led_index, input red, input green, input blue, output ready);
endinterface

interface aled_csr_if;
   logic                        valid;
   logic                        ready;
   logic [aled_pkg::CNT_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/addressable_led_pulse_decoder_top.sv
// Top level of the addressable LED pulse decoder: front, queue, back and
// the LED count register. Depends on aled_pkg, the channel interfaces,
// aled_front, aled_fifo, aled_back and the assertion macro header.
//
//   channel   direction   handshake      carries
//   req_ch    in          valid/ready    edge_rising, interval_ps
//   rsp_ch    out         valid/ready    out_drive .. blue, one word per edge
//   csr_ch    in          valid/ready    led_count (always ready)
//
// One edge word per clock sustained when nothing stalls; a word passes from
// req_ch to rsp_ch through the queue, then the result register.
// The front stalls only when the QUEUE_DEPTH-entry queue is full; the back
// stalls only while the result register is held by rsp_ch.
// Reset is synchronous; the block accepts edges in the cycle after reset.
// Colour words leave on rsp_ch for storage outside the block.
`timescale 1ns / 1ps
`include "addressable_led_pulse_decoder_top_defines.svh"

module addressable_led_pulse_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   aled_req_if.sink   req_ch,
   aled_rsp_if.source rsp_ch,
   aled_csr_if.sink   csr_ch
);

   localparam int CLASS_W = $bits(aled_pkg::edge_class_type);

   logic [aled_pkg::CNT_W-1:0] led_count_ff;
   logic                       push_valid;
   logic                       queue_full;
   logic                       queue_pop;
   logic                       queue_valid;
   aled_pkg::edge_class_type   push_data;
   aled_pkg::edge_class_type   queue_data;

   // Take configuration writes at once
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= aled_pkg::CNT_W'(1);
      end else if (csr_ch.valid) begin
         led_count_ff <= csr_ch.data;
      end
   end

   aled_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   aled_fifo #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_data)
   );

   aled_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .led_count   (led_count_ff),
      .rsp_ch      (rsp_ch)
   );

   // Pass-through and colour writes never coincide
   `ALED_ASSERT_SAME(a_drive_no_write, clock, reset, rsp_ch.valid && rsp_ch.out_drive, !rsp_ch.led_write, "pass-through and colour write in one word")

   // A driven level needs the drive flag
   `ALED_ASSERT_SAME(a_level_needs_drive, clock, reset, rsp_ch.valid && rsp_ch.out_level, rsp_ch.out_drive, "level set without drive")

   // A colour write lands below the configured count
   `ALED_ASSERT_SAME(a_write_in_range, clock, reset, rsp_ch.valid && rsp_ch.led_write, {1'b0, rsp_ch.led_index} < led_count_ff, "colour write beyond LED count")

   // An edge taken from the queue shows up in the result register next
   `ALED_ASSERT_NEXT(a_pop_gives_word, clock, reset, queue_pop, rsp_ch.valid, "taken edge gave no result word")

endmodule

FILE: design/aled_front.sv
// Front end: accepts edge words and classifies the interval against the
// pulse timing windows. Depends on aled_pkg and aled_req_if.
`timescale 1ns / 1ps

module aled_front (
   aled_req_if.sink                 req_ch,
   input  logic                     queue_full,
   output logic                     push_valid,
   output aled_pkg::edge_class_type push_data
);

   logic [aled_pkg::T_W-1:0] t;

   assign t = req_ch.interval_ps;

   // Accept whenever the queue has room
   assign req_ch.ready = !queue_full;
   assign push_valid   = req_ch.valid && !queue_full;

   // Compare the interval against every window at once
   always_comb begin
      push_data.rising      = req_ch.edge_rising;
      push_data.frame_reset = t > aled_pkg::T_FRAME_RESET;
      push_data.low_ok      = (t > aled_pkg::T_LOW_MIN) && (t < aled_pkg::T_LOW_MAX);
      push_data.low_one     = t < aled_pkg::T_LOW_ONE_MAX;
      push_data.low_zero    = t > aled_pkg::T_LOW_ZERO_MIN;
      push_data.high_ok     = (t > aled_pkg::T_HIGH_MIN) && (t < aled_pkg::T_HIGH_MAX);
      push_data.high_long   = t > aled_pkg::T_HIGH_LONG;
   end

endmodule

FILE: design/aled_fifo.sv
// Short queue of classified edges between front and back.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module aled_fifo #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/aled_back.sv
// Back end: decodes classified edges into bits, bytes and colour words,
// drives pass-through and holds the result register. Depends on aled_pkg
// and aled_rsp_if.
`timescale 1ns / 1ps

module aled_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_valid,
   input  aled_pkg::edge_class_type   queue_data,
   output logic                       queue_pop,
   input  logic [aled_pkg::CNT_W-1:0] led_count,
   aled_rsp_if.source                 rsp_ch
);

   localparam logic [aled_pkg::CNT_W-1:0] MAX_CNT = aled_pkg::CNT_W'(aled_pkg::MAX_LEDS);

   // Decoder state
   logic [7:0]                 acc_ff, acc_in;
   logic [2:0]                 bit_pos_ff, bit_pos_in;
   logic [1:0]                 byte_idx_ff, byte_idx_in;
   logic [aled_pkg::CNT_W-1:0] led_cnt_ff, led_cnt_in;
   logic [7:0]                 first_ff, first_in;
   logic [7:0]                 second_ff, second_in;
   logic                       high_long_ff, high_long_in;
   logic                       save_rise_ff, save_rise_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       drive_ff, level_ff, write_ff;
   logic [aled_pkg::IDX_W-1:0] index_ff;
   logic [7:0]                 red_ff, green_ff, blue_ff;

   // Per-edge decode
   logic                       drive, level, do_store, store_val, wr;
   logic [aled_pkg::IDX_W-1:0] wr_index;
   logic [7:0]                 wr_r, wr_g, wr_b;
   logic [7:0]                 acc_set;
   logic [aled_pkg::CNT_W-1:0] eff_count;
   logic                       passing;

   // Take the next edge when the result register is free or being emptied
   assign queue_pop = queue_valid && (!rsp_valid_ff || rsp_ch.ready);

   assign eff_count = (led_count > MAX_CNT) ? MAX_CNT : led_count;
   assign passing   = led_cnt_ff >= eff_count;

   // Decode one edge and work out the next state
   always_comb begin
      acc_in       = acc_ff;
      bit_pos_in   = bit_pos_ff;
      byte_idx_in  = byte_idx_ff;
      led_cnt_in   = led_cnt_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      high_long_in = high_long_ff;
      save_rise_in = save_rise_ff;
      drive        = 1'b0;
      level        = 1'b0;
      do_store     = 1'b0;
      store_val    = 1'b0;
      wr           = 1'b0;
      wr_index     = '0;
      wr_r         = '0;
      wr_g         = '0;
      wr_b         = '0;
      acc_set      = acc_ff;

      if (queue_data.rising) begin
         if (queue_data.frame_reset) begin
            acc_in      = '0;
            bit_pos_in  = 3'd7;
            byte_idx_in = aled_pkg::BYTE_GREEN;
            led_cnt_in  = '0;
         end else if (queue_data.low_ok) begin
            if (passing) begin
               drive = 1'b1;
               level = 1'b1;
            end else if (save_rise_ff) begin
               if (high_long_ff) begin
                  do_store  = queue_data.low_one;
                  store_val = 1'b1;
               end else begin
                  do_store  = queue_data.low_zero;
                  store_val = 1'b0;
               end
            end
         end
         save_rise_in = 1'b1;
      end else begin
         if (passing) begin
            drive = 1'b1;
         end else if (queue_data.high_ok) begin
            high_long_in = queue_data.high_long;
            if (byte_idx_ff >= aled_pkg::BYTE_BLUE && bit_pos_ff == 3'd0) begin
               do_store     = 1'b1;
               store_val    = queue_data.high_long;
               save_rise_in = 1'b0;
            end
         end
      end

      // Shift a bit in, MSB first, and close bytes and colours
      if (do_store) begin
         acc_set[bit_pos_ff] = store_val;
         if (bit_pos_ff != 3'd0) begin
            bit_pos_in = bit_pos_ff - 3'd1;
            acc_in     = acc_set;
         end else begin
            bit_pos_in = 3'd7;
            acc_in     = '0;
            unique case (byte_idx_ff)
               aled_pkg::BYTE_GREEN: begin
                  first_in    = acc_set;
                  byte_idx_in = aled_pkg::BYTE_RED;
               end
               aled_pkg::BYTE_RED: begin
                  second_in   = acc_set;
                  byte_idx_in = aled_pkg::BYTE_BLUE;
               end
               default: begin
                  if (led_cnt_ff < MAX_CNT) begin
                     wr         = 1'b1;
                     wr_index   = led_cnt_ff[aled_pkg::IDX_W-1:0];
                     wr_r       = second_ff;
                     wr_g       = first_ff;
                     wr_b       = acc_set;
                     led_cnt_in = led_cnt_ff + 1'b1;
                  end
                  byte_idx_in = aled_pkg::BYTE_GREEN;
               end
            endcase
         end
      end
   end

   assign rsp_valid_in = queue_pop || (rsp_valid_ff && !rsp_ch.ready);

   // Advance decoder state on each taken edge
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         bit_pos_ff   <= 3'd7;
         byte_idx_ff  <= aled_pkg::BYTE_GREEN;
         led_cnt_ff   <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         high_long_ff <= 1'b0;
         save_rise_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (queue_pop) begin
            acc_ff       <= acc_in;
            bit_pos_ff   <= bit_pos_in;
            byte_idx_ff  <= byte_idx_in;
            led_cnt_ff   <= led_cnt_in;
            first_ff     <= first_in;
            second_ff    <= second_in;
            high_long_ff <= high_long_in;
            save_rise_ff <= save_rise_in;
         end
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         drive_ff <= drive;
         level_ff <= drive && level;
         write_ff <= wr;
         index_ff <= wr_index;
         red_ff   <= wr_r;
         green_ff <= wr_g;
         blue_ff  <= wr_b;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_drive = drive_ff;
   assign rsp_ch.out_level = level_ff;
   assign rsp_ch.led_write = write_ff;
   assign rsp_ch.led_index = index_ff;
   assign rsp_ch.red       = red_ff;
   assign rsp_ch.green     = green_ff;
   assign rsp_ch.blue      = blue_ff;

endmodule

FILE: tb/led_decode_checker.sv
// Result checker for the addressable LED pulse decoder: watches the edge, result
// and count-register channels, predicts every result word and compares it.
// Depends on aled_pkg and the channel interfaces in aled_if.sv.
`timescale 1ns / 1ps

module led_decode_checker (
   input  logic clock,
   input  logic reset,
   aled_req_if  req_ch,
   aled_rsp_if  rsp_ch,
   aled_csr_if  csr_ch,
   output int   mismatches,
   output int   pending,
   output int   words_checked,
   output int   colours_written,
   output int   drives_seen
);

   typedef struct packed {
      logic                       drive;
      logic                       level;
      logic                       write;
      logic [aled_pkg::IDX_W-1:0] index;
      logic [7:0]                 red;
      logic [7:0]                 green;
      logic [7:0]                 blue;
   } led_word_type;

   // Decoder state as seen by the prediction
   logic [aled_pkg::CNT_W-1:0] led_count_q;
   logic [7:0]                 acc;
   logic [2:0]                 bit_pos;
   logic [1:0]                 byte_slot;
   logic [aled_pkg::CNT_W-1:0] leds_filled;
   logic [7:0]                 green_byte;
   logic [7:0]                 red_byte;
   logic                       high_long;
   logic                       save_on_rise;
   led_word_type               word_now;
   led_word_type               want;

   led_word_type expected_words[$];

   task automatic report_fault(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (got_val !== exp_val)
         report_fault($sformatf("word %0d %s: expected %0d, got %0d",
                                words_checked, name, exp_val, got_val));
   endtask

   function automatic void clear_decoder();
      led_count_q  = aled_pkg::CNT_W'(1);
      acc          = '0;
      bit_pos      = 3'd7;
      byte_slot    = aled_pkg::BYTE_GREEN;
      leds_filled  = '0;
      green_byte   = '0;
      red_byte     = '0;
      high_long    = 1'b0;
      save_on_rise = 1'b1;
   endfunction

   // Shift one decoded bit in, MSB first; a full blue byte completes a colour
   function automatic void shift_in_bit(input logic one);
      acc[bit_pos] = one;
      if (bit_pos != 3'd0) begin
         bit_pos = bit_pos - 3'd1;
         return;
      end
      bit_pos = 3'd7;
      if (byte_slot == aled_pkg::BYTE_GREEN) begin
         green_byte = acc;
         byte_slot  = aled_pkg::BYTE_RED;
      end else if (byte_slot == aled_pkg::BYTE_RED) begin
         red_byte  = acc;
         byte_slot = aled_pkg::BYTE_BLUE;
      end else begin
         if (int'(leds_filled) < aled_pkg::MAX_LEDS) begin
            word_now.write = 1'b1;
            word_now.index = leds_filled[aled_pkg::IDX_W-1:0];
            word_now.red   = red_byte;
            word_now.green = green_byte;
            word_now.blue  = acc;
            leds_filled    = leds_filled + 1'b1;
         end
         byte_slot = aled_pkg::BYTE_GREEN;
      end
      acc = '0;
   endfunction

   // Work out the result word that one edge causes
   function automatic led_word_type predict_edge(input logic rising,
                                                 input logic [aled_pkg::T_W-1:0] t);
      int   limit;
      logic passing;
      limit    = (int'(led_count_q) > aled_pkg::MAX_LEDS) ? aled_pkg::MAX_LEDS
                                                          : int'(led_count_q);
      passing  = int'(leds_filled) >= limit;
      word_now = '0;
      if (rising) begin
         if (t > aled_pkg::T_FRAME_RESET) begin
            acc         = '0;
            bit_pos     = 3'd7;
            byte_slot   = aled_pkg::BYTE_GREEN;
            leds_filled = '0;
         end else if (t > aled_pkg::T_LOW_MIN && t < aled_pkg::T_LOW_MAX) begin
            if (passing) begin
               word_now.drive = 1'b1;
               word_now.level = 1'b1;
            end else if (save_on_rise) begin
               if (high_long) begin
                  if (t < aled_pkg::T_LOW_ONE_MAX) shift_in_bit(1'b1);
               end else if (t > aled_pkg::T_LOW_ZERO_MIN) begin
                  shift_in_bit(1'b0);
               end
            end
         end
         save_on_rise = 1'b1;
      end else if (passing) begin
         word_now.drive = 1'b1;
         word_now.level = 1'b0;
      end else if (t > aled_pkg::T_HIGH_MIN && t < aled_pkg::T_HIGH_MAX) begin
         high_long = t > aled_pkg::T_HIGH_LONG;
         // last blue bit is taken on the falling edge
         if (byte_slot >= aled_pkg::BYTE_BLUE && bit_pos == 3'd0) begin
            shift_in_bit(high_long);
            save_on_rise = 1'b0;
         end
      end
      return word_now;
   endfunction

   // Predict on accepted edge words, compare accepted result words in order
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         expected_words.delete();
         mismatches      = 0;
         pending         = 0;
         words_checked   = 0;
         colours_written = 0;
         drives_seen     = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_words.push_back(predict_edge(req_ch.edge_rising, req_ch.interval_ps));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               report_fault("result word with no edge word waiting");
            end else begin
               want = expected_words.pop_front();
               check_field("out_drive", 32'(want.drive), 32'(rsp_ch.out_drive));
               check_field("out_level", 32'(want.level), 32'(rsp_ch.out_level));
               check_field("led_write", 32'(want.write), 32'(rsp_ch.led_write));
               check_field("led_index", 32'(want.index), 32'(rsp_ch.led_index));
               check_field("red", 32'(want.red), 32'(rsp_ch.red));
               check_field("green", 32'(want.green), 32'(rsp_ch.green));
               check_field("blue", 32'(want.blue), 32'(rsp_ch.blue));
               if (want.write) colours_written++;
               if (want.drive) drives_seen++;
            end
            words_checked++;
         end
         if (csr_ch.valid && csr_ch.ready) led_count_q = csr_ch.data;
         pending = expected_words.size();
      end
   end

endmodule

FILE: tb/tb_addressable_led_pulse_decoder_top.sv
// Testbench top for the addressable LED pulse decoder: drives edge words, LED
// count writes and result back-pressure, and gives the verdict from the checker.
// Depends on aled_pkg, aled_if.sv, led_decode_checker and the block itself.
`timescale 1ns / 1ps

module tb_addressable_led_pulse_decoder_top;

   localparam int RUN_LIMIT_NS = 40_000_000;
   localparam int RANDOM_EDGES = 900;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aled_req_if req_ch ();
   aled_rsp_if rsp_ch ();
   aled_csr_if csr_ch ();

   int mismatches;
   int pending;
   int words_checked;
   int colours_written;
   int drives_seen;

   int                         burst_left = 0;
   int                         edges_sent = 0;
   int                         stall_left = 0;
   int unsigned                cycles     = 0;
   logic [aled_pkg::CNT_W-1:0] cur_count  = aled_pkg::CNT_W'(1);
   int                         random_start;
   int                         n_leds;

   addressable_led_pulse_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   led_decode_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .mismatches      (mismatches),
      .pending         (pending),
      .words_checked   (words_checked),
      .colours_written (colours_written),
      .drives_seen     (drives_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result back-pressure: quiet windows alternate with windows of random stalls
   always @(negedge clock) begin
      cycles <= cycles + 1;
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (cycles[9] && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 8);
      end
   end

   // Send one edge word; the sender works in bursts with random gaps between
   task automatic send_edge(input logic rising, input logic [aled_pkg::T_W-1:0] t);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_ch.valid       <= 1'b1;
      req_ch.edge_rising <= rising;
      req_ch.interval_ps <= t;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      burst_left--;
      edges_sent++;
   endtask

   // Hold the sender until every result word is back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_led_count(input logic [aled_pkg::CNT_W-1:0] n);
      wait_for_results();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= n;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      cur_count = n;
   endtask

   // One data bit: a high pulse then a low gap, both inside their windows
   task automatic send_led_bit(input logic one);
      send_edge(1'b0, one ? $urandom_range(aled_pkg::T_HIGH_LONG + 1, aled_pkg::T_HIGH_MAX - 1)
                          : $urandom_range(aled_pkg::T_HIGH_MIN + 1, aled_pkg::T_HIGH_LONG));
      send_edge(1'b1, one ? $urandom_range(aled_pkg::T_LOW_MIN + 1, aled_pkg::T_LOW_ONE_MAX - 1)
                          : $urandom_range(aled_pkg::T_LOW_ZERO_MIN + 1,
                                           aled_pkg::T_LOW_MAX - 1));
   endtask

   task automatic send_colour(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      logic [23:0] bits;
      bits = {g, r, b};
      for (int i = 23; i >= 0; i--) send_led_bit(bits[i]);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Interval mix: full range, near thresholds, around the bit windows, up past a frame gap
   function automatic logic [aled_pkg::T_W-1:0] pick_interval();
      logic [aled_pkg::T_W-1:0] limits [8];
      limits = '{aled_pkg::T_FRAME_RESET, aled_pkg::T_LOW_MIN, aled_pkg::T_LOW_MAX,
                 aled_pkg::T_LOW_ONE_MAX, aled_pkg::T_LOW_ZERO_MIN, aled_pkg::T_HIGH_MIN,
                 aled_pkg::T_HIGH_MAX, aled_pkg::T_HIGH_LONG};
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return limits[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
         2:       return $urandom_range(150_000, 1_000_000);
         default: return $urandom_range(0, 60_000_000);
      endcase
   endfunction

   // A frame: optional restart, colours (noisy ones get stray edges and cut colours),
   // then edges meant for the pass-through output
   task automatic run_frame(input int leds, input bit restart, input int n_pass,
                            input bit noisy);
      if (restart) send_edge(1'b1, $urandom_range(aled_pkg::T_FRAME_RESET + 1, 32'hFFFF_FFFF));
      for (int i = 0; i < leds; i++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_edge(1'($urandom_range(0, 1)), pick_interval());
         if (noisy && $urandom_range(0, 15) == 0)
            repeat ($urandom_range(1, 20)) send_led_bit(1'($urandom_range(0, 1)));
         else
            send_colour(pick_byte(), pick_byte(), pick_byte());
      end
      for (int i = 0; i < n_pass; i++) send_edge(1'(i % 2), pick_interval());
   endtask

   initial begin
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d result words outstanding", pending);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.edge_rising = 1'b0;
      req_ch.interval_ps = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      rsp_ch.ready       = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Threshold edges: each bound just inside and just outside, plus field extremes
      send_edge(1'b1, 32'hFFFF_FFFF);
      send_edge(1'b0, 32'd0);
      send_edge(1'b1, aled_pkg::T_FRAME_RESET);
      send_edge(1'b0, aled_pkg::T_HIGH_MIN);
      send_edge(1'b0, aled_pkg::T_HIGH_MIN + 1);
      send_edge(1'b1, aled_pkg::T_LOW_ZERO_MIN);
      send_edge(1'b0, aled_pkg::T_HIGH_LONG);
      send_edge(1'b1, aled_pkg::T_LOW_ZERO_MIN + 1);
      send_edge(1'b0, aled_pkg::T_HIGH_LONG + 1);
      send_edge(1'b1, aled_pkg::T_LOW_ONE_MAX);
      send_edge(1'b0, aled_pkg::T_HIGH_MAX - 1);
      send_edge(1'b1, aled_pkg::T_LOW_ONE_MAX - 1);
      send_edge(1'b0, aled_pkg::T_HIGH_MAX);
      send_edge(1'b1, aled_pkg::T_LOW_MIN);
      send_edge(1'b1, aled_pkg::T_LOW_MIN + 1);
      send_edge(1'b0, 32'd700_000);
      send_edge(1'b1, aled_pkg::T_LOW_MAX);
      send_edge(1'b0, 32'd300_000);
      send_edge(1'b1, aled_pkg::T_LOW_MAX - 1);
      send_edge(1'b1, aled_pkg::T_FRAME_RESET + 1);

      // Extreme colours, then pass-through edges in and out of the low window
      write_led_count(aled_pkg::CNT_W'(2));
      send_edge(1'b1, 32'hFFFF_FFFF);
      send_colour(8'hFF, 8'h00, 8'hFF);
      send_colour(8'h00, 8'hFF, 8'h00);
      run_frame(0, 1'b0, 10, 1'b0);

      // Zero count: everything passes through
      write_led_count(aled_pkg::CNT_W'(0));
      run_frame(1, 1'b1, 6, 1'b0);

      // Lower the count below the LEDs already filled, then raise it again
      write_led_count(aled_pkg::CNT_W'(4));
      run_frame(3, 1'b1, 0, 1'b0);
      write_led_count(aled_pkg::CNT_W'(2));
      run_frame(0, 1'b0, 6, 1'b0);
      write_led_count(aled_pkg::CNT_W'(5));
      run_frame(2, 1'b0, 4, 1'b0);

      // Oversized count and a count equal to the store size
      write_led_count(11'h7FF);
      run_frame(3, 1'b1, 8, 1'b0);
      write_led_count(aled_pkg::CNT_W'(aled_pkg::MAX_LEDS));
      run_frame(2, 1'b1, 4, 1'b0);

      // Random frames with noise, cut colours and count changes between them
      random_start = edges_sent;
      while (edges_sent - random_start < RANDOM_EDGES) begin
         if ($urandom_range(0, 2) == 0)
            write_led_count(aled_pkg::CNT_W'($urandom_range(0, 9) < 8
                                             ? $urandom_range(0, 5)
                                             : $urandom_range(6, 12)));
         n_leds = int'(cur_count);
         if (n_leds > 0 && $urandom_range(0, 4) == 0) n_leds--;
         run_frame(n_leds, $urandom_range(0, 9) != 0, $urandom_range(0, 8), 1'b1);
      end

      wait_for_results();
      repeat (6) @(negedge clock);
      $display("Checked %0d result words: %0d colour writes, %0d pass-through drives.",
               words_checked, colours_written, drives_seen);
      $display("LED count went through 0, 1024, 2047 and small values, with noisy frames.");
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: addressable_led_pulse_decoder_top.f
+incdir+design
design/aled_pkg.sv
design/aled_if.sv
design/aled_front.sv
design/aled_fifo.sv
design/aled_back.sv
design/addressable_led_pulse_decoder_top.sv
tb/led_decode_checker.sv
tb/tb_addressable_led_pulse_decoder_top.sv
